// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// File: src/gdnr_pkg.sv
// ---------------------------------------------------------------------------
// gdnr_pkg
// Types, widths and calendar tables for the Gregorian day-number register.
// ---------------------------------------------------------------------------
package gdnr_pkg;

    // Field widths
    localparam int COUNT_W = 22;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFFS_W  = 21;

    // Working widths of the shared compare-subtract unit
    localparam int REM_W   = 23;
    localparam int ACC_W   = 24;

    // Calendar decomposition steps: 400-year cycles, centuries,
    // four-year blocks, single years
    localparam int          STEPS     = 15;
    localparam int          STEP_W    = 4;
    localparam logic [3:0]  LAST_STEP = 4'(STEPS - 1);

    // Request kinds
    typedef enum logic [2:0] {
        KIND_SET_DATE  = 3'd0,
        KIND_LOAD      = 3'd1,
        KIND_ADD       = 3'd2,
        KIND_SET_YEAR  = 3'd3,
        KIND_SET_MONTH = 3'd4,
        KIND_SET_DAY   = 3'd5,
        KIND_READ      = 3'd6
    } t_kind;

    // Result of one compare-subtract-accumulate step
    typedef struct packed {
        logic                    ge;
        logic [REM_W-1:0]        rem;
        logic signed [ACC_W-1:0] acc;
    } t_step_res;

    // Year weight of a decomposition step
    function automatic logic [YEAR_W-1:0] f_year_w(input logic [STEP_W-1:0] step);
        logic [YEAR_W-1:0] w;
        unique case (step)
            4'd0:    w = 14'd12800;
            4'd1:    w = 14'd6400;
            4'd2:    w = 14'd3200;
            4'd3:    w = 14'd1600;
            4'd4:    w = 14'd800;
            4'd5:    w = 14'd400;
            4'd6:    w = 14'd200;
            4'd7:    w = 14'd100;
            4'd8:    w = 14'd64;
            4'd9:    w = 14'd32;
            4'd10:   w = 14'd16;
            4'd11:   w = 14'd8;
            4'd12:   w = 14'd4;
            4'd13:   w = 14'd2;
            4'd14:   w = 14'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Day weight of a decomposition step (days in that many years)
    function automatic logic [REM_W-1:0] f_day_w(input logic [STEP_W-1:0] step);
        logic [REM_W-1:0] w;
        unique case (step)
            4'd0:    w = 23'd4675104;
            4'd1:    w = 23'd2337552;
            4'd2:    w = 23'd1168776;
            4'd3:    w = 23'd584388;
            4'd4:    w = 23'd292194;
            4'd5:    w = 23'd146097;
            4'd6:    w = 23'd73048;
            4'd7:    w = 23'd36524;
            4'd8:    w = 23'd23376;
            4'd9:    w = 23'd11688;
            4'd10:   w = 23'd5844;
            4'd11:   w = 23'd2922;
            4'd12:   w = 23'd1461;
            4'd13:   w = 23'd730;
            4'd14:   w = 23'd365;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Days before a month in a common year; index 13 is the whole year
    function automatic logic [8:0] f_cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] c;
        unique case (m)
            4'd0, 4'd1: c = 9'd0;
            4'd2:       c = 9'd31;
            4'd3:       c = 9'd59;
            4'd4:       c = 9'd90;
            4'd5:       c = 9'd120;
            4'd6:       c = 9'd151;
            4'd7:       c = 9'd181;
            4'd8:       c = 9'd212;
            4'd9:       c = 9'd243;
            4'd10:      c = 9'd273;
            4'd11:      c = 9'd304;
            4'd12:      c = 9'd334;
            default:    c = 9'd365;
        endcase
        return c;
    endfunction

    // Length of a month, February by the leap flag
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] l;
        unique case (m)
            4'd2:                            l = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:         l = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                    l = 5'd31;
            default:                         l = 5'd0;
        endcase
        return l;
    endfunction

    // Leap flag from the step outcomes: year is a multiple of four when the
    // single-year digit is three, a century when also the block digit is 24,
    // and a multiple of 400 when also the century digit is three
    function automatic logic f_leap_of_steps(input logic [STEPS-1:0] q);
        logic [1:0] q100;
        logic [4:0] q4;
        logic [1:0] q1;
        q100 = {q[6], q[7]};
        q4   = {q[8], q[9], q[10], q[11], q[12]};
        q1   = {q[13], q[14]};
        return (q1 == 2'd3) && ((q4 != 5'd24) || (q100 == 2'd3));
    endfunction

endpackage

// File: src/gdnr_step_unit.sv
// ---------------------------------------------------------------------------
// gdnr_step_unit
// Shared compare-subtract-accumulate step: when the remainder reaches the
// compare value, subtract it and add the weight to the accumulator.
// ---------------------------------------------------------------------------
module gdnr_step_unit (
    input  logic [gdnr_pkg::REM_W-1:0]        i_rem,
    input  logic [gdnr_pkg::REM_W-1:0]        i_cmp,
    input  logic signed [gdnr_pkg::ACC_W-1:0] i_acc,
    input  logic [gdnr_pkg::REM_W-1:0]        i_add,
    output gdnr_pkg::t_step_res               o_res
);
    import gdnr_pkg::*;

    logic [REM_W:0] w_diff;

    // Compare by subtraction; the borrow says the remainder is short
    assign w_diff    = {1'b0, i_rem} - {1'b0, i_cmp};
    assign o_res.ge  = ~w_diff[REM_W];
    assign o_res.rem = o_res.ge ? w_diff[REM_W-1:0] : i_rem;
    assign o_res.acc = o_res.ge ? (i_acc + $signed({1'b0, i_add})) : i_acc;

endmodule

// File: src/gregorian_day_number_register_top.sv
// ---------------------------------------------------------------------------
// gregorian_day_number_register_top
// Day-count register of the proleptic Gregorian calendar with date loads,
// offset adds, field replacement and conversion back to year, month, day.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side takes one request per handshake: tuser holds the kind, tdata
//   the year, month, day, offset and count operands. Master side returns one
//   result per request: tdata holds count, year, month and day, tuser the
//   leap and range-error flags.
//   A read returns the stored date through the output stage; a load or add
//   clamps the new count and converts it back to year, month and day; a
//   date or field set first turns the date into a count (year zero skips
//   the year steps), then clamps and converts back like a load.
//   One request is in work at a time; s_axis_tready is high only while the
//   sequencer is idle and reset is released. The sequencer uses one shared
//   compare-subtract unit that walks 15 calendar steps (400-year cycles down
//   to single years) per conversion direction plus up to 11 month steps.
//   A finished result sits in the output register; the next request is
//   taken meanwhile and holds in its last step while the receiver stalls.
//   Reset sets the count to 1 (1 January of year 1) and empties the output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gregorian_day_number_register_top #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // year_in[13:0], month_in[17:14], day_in[22:18], offset[43:23],
    // count_in[65:44], zero pad[71:66]
    input  logic [71:0] i_s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    // Result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // count_out[21:0], year_out[35:22], month_out[39:36], day_out[44:40],
    // zero pad[47:45]
    output logic [47:0] o_m_axis_tdata,
    // is_leap[0], range_error[1]
    output logic [1:0]  o_m_axis_tuser
);
    import gdnr_pkg::*;

    // Count of 31 December of the last year
    localparam int MAX_COUNT = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                               + MAX_YEAR / 400;
    localparam logic [COUNT_W-1:0]      MAX_CNT = COUNT_W'(MAX_COUNT);
    localparam logic signed [ACC_W-1:0] MAX_ACC = ACC_W'(MAX_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Y2C,
        ST_M2C,
        ST_CLAMP,
        ST_C2Y,
        ST_C2M,
        ST_OUT
    } t_state;

    // Registers
    t_state                  r_state,     n_state;
    logic [STEP_W-1:0]       r_step,      n_step;
    logic [STEPS-1:0]        r_qbits,     n_qbits;
    logic [REM_W-1:0]        r_rem,       n_rem;
    logic signed [ACC_W-1:0] r_acc,       n_acc;
    logic [MONTH_W-1:0]      r_tm,        n_tm;
    logic [DAY_W-1:0]        r_td,        n_td;
    logic                    r_tleap,     n_tleap;
    logic [COUNT_W-1:0]      r_count,     n_count;
    logic [YEAR_W-1:0]       r_year,      n_year;
    logic [MONTH_W-1:0]      r_mon,       n_mon;
    logic [DAY_W-1:0]        r_day,       n_day;
    logic                    r_leap,      n_leap;
    logic                    r_err,       n_err;
    logic                    r_out_valid, n_out_valid;
    logic [47:0]             r_out_data,  n_out_data;
    logic [1:0]              r_out_user,  n_out_user;

    // Request fields
    t_kind                   w_kind;
    logic [YEAR_W-1:0]       w_year_in;
    logic [MONTH_W-1:0]      w_month_in;
    logic [DAY_W-1:0]        w_day_in;
    logic signed [OFFS_W-1:0] w_offset;
    logic [COUNT_W-1:0]      w_count_in;

    // Sequencer helpers
    logic                    w_accept;
    logic [YEAR_W-1:0]       w_sel_y;
    logic [MONTH_W-1:0]      w_sel_m;
    logic [DAY_W-1:0]        w_sel_d;
    logic [MONTH_W-1:0]      w_mm;
    logic                    w_adj;
    logic [STEPS-1:0]        w_qbits;
    logic [REM_W-1:0]        u_cmp;
    logic [REM_W-1:0]        u_add;
    t_step_res               u_res;

    // Unpack the request
    assign w_kind     = t_kind'(i_s_axis_tuser);
    assign w_year_in  = i_s_axis_tdata[13:0];
    assign w_month_in = i_s_axis_tdata[17:14];
    assign w_day_in   = i_s_axis_tdata[22:18];
    assign w_offset   = $signed(i_s_axis_tdata[43:23]);
    assign w_count_in = i_s_axis_tdata[65:44];

    // Take requests only when idle and out of reset
    assign o_s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // Month index clamped to a whole year; February 29 shifts later months
    assign w_mm    = (r_tm > 4'd13) ? 4'd13 : r_tm;
    assign w_adj   = r_tleap && (w_mm > 4'd2);
    assign w_qbits = r_qbits | (STEPS'(u_res.ge) << r_step);

    // Pick the target date by kind: take the request date, or replace one field of the stored date
    always_comb begin
        w_sel_y = w_year_in;
        w_sel_m = w_month_in;
        w_sel_d = w_day_in;
        unique case (w_kind) inside
            KIND_SET_YEAR: begin
                w_sel_m = r_mon;
                w_sel_d = r_day;
            end
            KIND_SET_MONTH: begin
                w_sel_y = r_year;
                w_sel_d = r_day;
            end
            KIND_SET_DAY: begin
                w_sel_y = r_year;
                w_sel_m = r_mon;
            end
            default: ;
        endcase
    end

    // Feed the shared unit for the current sequencer step
    always_comb begin
        u_cmp = '0;
        u_add = '0;
        unique case (r_state)
            ST_Y2C: begin
                u_cmp = REM_W'(f_year_w(r_step));
                u_add = f_day_w(r_step);
            end
            ST_M2C: begin
                u_add = REM_W'(f_cum_days(w_mm)) + REM_W'(w_adj) + REM_W'(r_td);
            end
            ST_C2Y: begin
                u_cmp = f_day_w(r_step);
                u_add = REM_W'(f_year_w(r_step));
            end
            ST_C2M: begin
                u_cmp = REM_W'(f_month_len(r_acc[MONTH_W-1:0], r_leap));
                u_add = REM_W'(1);
            end
            default: ;
        endcase
    end

    gdnr_step_unit u_step (
        .i_rem (r_rem),
        .i_cmp (u_cmp),
        .i_acc (r_acc),
        .i_add (u_add),
        .o_res (u_res)
    );

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_qbits     = r_qbits;
        n_rem       = r_rem;
        n_acc       = r_acc;
        n_tm        = r_tm;
        n_td        = r_td;
        n_tleap     = r_tleap;
        n_count     = r_count;
        n_year      = r_year;
        n_mon       = r_mon;
        n_day       = r_day;
        n_leap      = r_leap;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        // Drop the result once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_kind) inside
                        KIND_SET_DATE, KIND_SET_YEAR, KIND_SET_MONTH,
                        KIND_SET_DAY: begin
                            n_tm = w_sel_m;
                            n_td = w_sel_d;
                            if (w_sel_y == '0) begin
                                // Year zero: leap year right before year one
                                n_acc   = -24'sd366;
                                n_tleap = 1'b1;
                                n_state = ST_M2C;
                            end else begin
                                n_rem   = {9'b0, w_sel_y - 14'd1};
                                n_acc   = '0;
                                n_step  = '0;
                                n_qbits = '0;
                                n_state = ST_Y2C;
                            end
                        end
                        KIND_LOAD: begin
                            n_acc   = $signed({2'b0, w_count_in});
                            n_state = ST_CLAMP;
                        end
                        KIND_ADD: begin
                            n_acc   = $signed({2'b0, r_count})
                                      + $signed({{3{w_offset[OFFS_W-1]}}, w_offset});
                            n_state = ST_CLAMP;
                        end
                        default: begin
                            n_err   = 1'b0;
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_Y2C: begin
                // Years before the target into days
                n_rem   = u_res.rem;
                n_acc   = u_res.acc;
                n_qbits = w_qbits;
                if (r_step == LAST_STEP) begin
                    n_tleap = f_leap_of_steps(w_qbits);
                    n_state = ST_M2C;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_M2C: begin
                // Whole months and the day
                n_acc   = u_res.acc;
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (r_acc < 24'sd1) begin
                    n_count = 22'd1;
                    n_err   = 1'b1;
                end else if (r_acc > MAX_ACC) begin
                    n_count = MAX_CNT;
                    n_err   = 1'b1;
                end else begin
                    n_count = r_acc[COUNT_W-1:0];
                    n_err   = 1'b0;
                end
                n_rem   = {1'b0, n_count} - 23'd1;
                n_acc   = 24'sd1;
                n_step  = '0;
                n_qbits = '0;
                n_state = ST_C2Y;
            end
            ST_C2Y: begin
                // Days into years; remainder is the day of the year
                n_rem   = u_res.rem;
                n_acc   = u_res.acc;
                n_qbits = w_qbits;
                if (r_step == LAST_STEP) begin
                    n_year  = u_res.acc[YEAR_W-1:0];
                    n_leap  = f_leap_of_steps(w_qbits);
                    n_acc   = 24'sd1;
                    n_state = ST_C2M;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_C2M: begin
                // Advance the month while the remainder covers it
                if (!u_res.ge || (r_acc[MONTH_W-1:0] == 4'd12)) begin
                    n_mon   = r_acc[MONTH_W-1:0];
                    n_day   = r_rem[DAY_W-1:0] + 5'd1;
                    n_state = ST_OUT;
                end else begin
                    n_rem = u_res.rem;
                    n_acc = u_res.acc;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b0, r_day, r_mon, r_year, r_count};
                    n_out_user  = {r_err, r_leap};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= 22'd1;
            r_year      <= 14'd1;
            r_mon       <= 4'd1;
            r_day       <= 5'd1;
            r_leap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_year      <= n_year;
            r_mon       <= n_mon;
            r_day       <= n_day;
            r_leap      <= n_leap;
            r_out_valid <= n_out_valid;
        end
        r_step     <= n_step;
        r_qbits    <= n_qbits;
        r_rem      <= n_rem;
        r_acc      <= n_acc;
        r_tm       <= n_tm;
        r_td       <= n_td;
        r_tleap    <= n_tleap;
        r_err      <= n_err;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    // Checks
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, (r_count == 22'd0) || (r_count > MAX_CNT), "stored count left 1..MAX")
    `ASSERT_AT(a_err_clamped, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> ((o_m_axis_tdata[21:0] == 22'd1) || (o_m_axis_tdata[21:0] == MAX_CNT)), "range error without clamped count")
    `ASSERT_AT(a_date_fields, i_clk, i_rst_n, o_m_axis_tvalid |-> ((o_m_axis_tdata[39:36] >= 4'd1) && (o_m_axis_tdata[39:36] <= 4'd12) && (o_m_axis_tdata[44:40] != 5'd0)), "result month or day out of range")
    `ASSERT_AT(a_step_bound, i_clk, i_rst_n, ((r_state == ST_Y2C) || (r_state == ST_C2Y)) |-> (r_step <= LAST_STEP), "step counter ran past the last calendar step")

endmodule
